[sv/ptwa_pkg.sv]
// ----------------------------------------------------------------------------
// ptwa_pkg
// Shared constants, datapath operation codes and the command and status
// structs passed between the page table walker controller and datapath.
// ----------------------------------------------------------------------------
package ptwa_pkg;

  // geometry
  localparam int OFFSET_BITS  = 4;
  localparam int VIRTUAL_BITS = 16;
  localparam int FRAME_COUNT  = 64;
  localparam int LEVELS       = 3;
  localparam int WORD_BITS    = 32;

  localparam int PG_WORDS     = 1 << OFFSET_BITS;
  localparam int PAGE_BITS    = VIRTUAL_BITS - OFFSET_BITS;
  localparam int PAGE_COUNT   = 1 << PAGE_BITS;
  localparam int FRAME_BITS   = $clog2(FRAME_COUNT);
  localparam int PHYS_AW      = FRAME_BITS + OFFSET_BITS;
  localparam int SWAP_AW      = VIRTUAL_BITS;
  localparam int DEPTH_BITS   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DIST_BITS    = PAGE_BITS + 1;
  localparam int CNT_BITS     = OFFSET_BITS + 1;

  // datapath operation codes
  localparam logic [4:0] OP_IDLE      = 5'd0;
  localparam logic [4:0] OP_CLEAR     = 5'd1;
  localparam logic [4:0] OP_LOAD      = 5'd2;
  localparam logic [4:0] OP_WALK_INIT = 5'd3;
  localparam logic [4:0] OP_WALK_RD   = 5'd4;
  localparam logic [4:0] OP_WALK_CHK  = 5'd5;
  localparam logic [4:0] OP_SCAN_INIT = 5'd6;
  localparam logic [4:0] OP_SCAN_RD   = 5'd7;
  localparam logic [4:0] OP_SCAN_CHK  = 5'd8;
  localparam logic [4:0] OP_SCAN_NEXT = 5'd9;
  localparam logic [4:0] OP_PICK      = 5'd10;
  localparam logic [4:0] OP_EVICT     = 5'd11;
  localparam logic [4:0] OP_UNLINK    = 5'd12;
  localparam logic [4:0] OP_ZERO      = 5'd13;
  localparam logic [4:0] OP_LINK      = 5'd14;
  localparam logic [4:0] OP_FILL      = 5'd15;
  localparam logic [4:0] OP_ACCESS    = 5'd16;
  localparam logic [4:0] OP_RESULT    = 5'd17;

  typedef struct packed {
    logic [4:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic va_bad;
    logic walk_zero;
    logic walk_last;
    logic fresh;
    logic scan_push;
    logic scan_more;
    logic scan_done;
    logic need_evict;
    logic copy_done;
    logic zero_done;
    logic clr_done;
  } dp_status_t;

endpackage

[sv/ptwa_dp.sv]
// ----------------------------------------------------------------------------
// ptwa_dp
// Datapath: request registers, physical and swap memories, walk registers,
// depth-first scan stack, victim and empty-table trackers, result register.
// ----------------------------------------------------------------------------
module ptwa_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_operation,
  input  logic [31:0]          in_virtual_address,
  input  logic signed [31:0]   in_write_data,
  input  ptwa_pkg::dp_cmd_t    cmd,
  output ptwa_pkg::dp_status_t status,
  output logic                 out_status,
  output logic signed [31:0]   out_read_data
);
  import ptwa_pkg::*;

  // request
  logic                 req_op_r;
  logic [31:0]          req_va_r;
  logic [31:0]          req_wd_r;

  // walk
  logic [FRAME_BITS-1:0] cur_r;
  logic [DEPTH_BITS-1:0] lvl_r;
  logic                  fresh_r;
  logic [FRAME_BITS-1:0] nf_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic [SWAP_AW-1:0]    clr_r;

  // scan stack, one entry per table depth
  logic [DEPTH_BITS-1:0]  dep_r;
  logic [FRAME_BITS-1:0]  frm_r   [LEVELS];
  logic [OFFSET_BITS-1:0] idx_r   [LEVELS];
  logic                   emp_r   [LEVELS];
  logic [PAGE_BITS-1:0]   pg_r    [LEVELS];
  logic [FRAME_BITS-1:0]  par_r   [LEVELS];
  logic [OFFSET_BITS-1:0] pslot_r [LEVELS];

  // scan results
  logic [FRAME_BITS-1:0]  top_r;
  logic                   has_e_r;
  logic [FRAME_BITS-1:0]  e_frame_r;
  logic [FRAME_BITS-1:0]  e_parent_r;
  logic [OFFSET_BITS-1:0] e_slot_r;
  logic                   has_v_r;
  logic [DIST_BITS-1:0]   v_dist_r;
  logic [FRAME_BITS-1:0]  v_frame_r;
  logic [PAGE_BITS-1:0]   v_page_r;
  logic [FRAME_BITS-1:0]  v_parent_r;
  logic [OFFSET_BITS-1:0] v_slot_r;

  // result
  logic                res_status_r;
  logic [31:0]         res_data_r;

  // memories
  logic [WORD_BITS-1:0] phys_mem [FRAME_COUNT*PG_WORDS];
  logic [WORD_BITS-1:0] swap_mem [1 << SWAP_AW];
  logic [WORD_BITS-1:0] phys_rdata_r;
  logic [WORD_BITS-1:0] swap_rdata_r;

  logic                 phys_we, phys_re, swap_we, swap_re;
  logic [PHYS_AW-1:0]   phys_wa, phys_ra;
  logic [SWAP_AW-1:0]   swap_wa, swap_ra;
  logic [WORD_BITS-1:0] phys_wd, swap_wd;

  // derived values
  logic [PAGE_BITS-1:0]   page;
  logic [OFFSET_BITS-1:0] off;
  logic                   va_bad;
  logic [OFFSET_BITS-1:0] walk_slot;
  logic                   walk_last;
  logic [WORD_BITS-1:0]   w;
  logic [FRAME_BITS-1:0]  w_frame;
  logic                   w_ok;
  logic [FRAME_BITS-1:0]  f_d;
  logic [OFFSET_BITS-1:0] i_d;
  logic [PAGE_BITS-1:0]   child_page;
  logic                   leaf_child;
  logic [PAGE_BITS-1:0]   lin;
  logic [DIST_BITS-1:0]   wrap;
  logic [DIST_BITS-1:0]   pg_dist;
  logic [CNT_BITS-1:0]    cnt_m1;
  logic [DEPTH_BITS-1:0]  dep_up;

  assign page       = req_va_r[VIRTUAL_BITS-1:OFFSET_BITS];
  assign off        = req_va_r[OFFSET_BITS-1:0];
  assign va_bad     = |req_va_r[31:VIRTUAL_BITS];
  assign walk_slot  = OFFSET_BITS'(page >> (OFFSET_BITS * (LEVELS - 1 - int'(lvl_r))));
  assign walk_last  = (lvl_r == DEPTH_BITS'(LEVELS - 1));
  assign w          = phys_rdata_r;
  assign w_frame    = w[FRAME_BITS-1:0];
  assign w_ok       = (w < WORD_BITS'(FRAME_COUNT));
  assign f_d        = frm_r[dep_r];
  assign i_d        = idx_r[dep_r];
  assign child_page = PAGE_BITS'({pg_r[dep_r], i_d});
  assign leaf_child = (dep_r == DEPTH_BITS'(LEVELS - 1));
  assign cnt_m1     = cnt_r - CNT_BITS'(1);
  assign dep_up     = dep_r + DEPTH_BITS'(1);

  // cyclic page distance between the request and a leaf
  always_comb begin
    lin     = (page > child_page) ? (page - child_page) : (child_page - page);
    wrap    = DIST_BITS'(PAGE_COUNT) - DIST_BITS'(lin);
    pg_dist = (DIST_BITS'(lin) < wrap) ? DIST_BITS'(lin) : wrap;
  end

  // status to controller
  always_comb begin
    status.va_bad     = va_bad;
    status.walk_zero  = (w == '0);
    status.walk_last  = walk_last;
    status.fresh      = fresh_r;
    status.scan_push  = (w != '0) && w_ok && !leaf_child;
    status.scan_more  = (i_d != OFFSET_BITS'(PG_WORDS - 1));
    status.scan_done  = (i_d == OFFSET_BITS'(PG_WORDS - 1)) && (dep_r == '0);
    status.need_evict = !has_e_r && (top_r == FRAME_BITS'(FRAME_COUNT - 1)) && has_v_r;
    status.copy_done  = (cnt_r == CNT_BITS'(PG_WORDS));
    status.zero_done  = (cnt_r == CNT_BITS'(PG_WORDS - 1));
    status.clr_done   = &clr_r;
  end

  // memory port selection
  always_comb begin
    phys_we = 1'b0;
    phys_re = 1'b0;
    phys_wa = '0;
    phys_ra = '0;
    phys_wd = '0;
    swap_we = 1'b0;
    swap_re = 1'b0;
    swap_wa = '0;
    swap_ra = '0;
    swap_wd = '0;
    case (cmd.op)
      OP_CLEAR: begin
        swap_we = 1'b1;
        swap_wa = clr_r;
        phys_we = (clr_r < SWAP_AW'(PG_WORDS));
        phys_wa = PHYS_AW'(clr_r[OFFSET_BITS-1:0]);
      end
      OP_WALK_RD: begin
        phys_re = 1'b1;
        phys_ra = {cur_r, walk_slot};
      end
      OP_SCAN_RD: begin
        phys_re = 1'b1;
        phys_ra = {f_d, i_d};
      end
      OP_PICK: begin
        phys_we = has_e_r;
        phys_wa = {e_parent_r, e_slot_r};
      end
      OP_EVICT: begin
        phys_re = (cnt_r < CNT_BITS'(PG_WORDS));
        phys_ra = {v_frame_r, cnt_r[OFFSET_BITS-1:0]};
        swap_we = (cnt_r != '0);
        swap_wa = {v_page_r, cnt_m1[OFFSET_BITS-1:0]};
        swap_wd = phys_rdata_r;
      end
      OP_UNLINK: begin
        phys_we = 1'b1;
        phys_wa = {v_parent_r, v_slot_r};
      end
      OP_ZERO: begin
        phys_we = 1'b1;
        phys_wa = {nf_r, cnt_r[OFFSET_BITS-1:0]};
      end
      OP_LINK: begin
        phys_we = 1'b1;
        phys_wa = {cur_r, walk_slot};
        phys_wd = WORD_BITS'(nf_r);
      end
      OP_FILL: begin
        swap_re = (cnt_r < CNT_BITS'(PG_WORDS));
        swap_ra = {page, cnt_r[OFFSET_BITS-1:0]};
        phys_we = (cnt_r != '0);
        phys_wa = {cur_r, cnt_m1[OFFSET_BITS-1:0]};
        phys_wd = swap_rdata_r;
      end
      OP_ACCESS: begin
        phys_we = req_op_r;
        phys_re = !req_op_r;
        phys_wa = {cur_r, off};
        phys_ra = {cur_r, off};
        phys_wd = WORD_BITS'($signed(req_wd_r));
      end
      default: begin
      end
    endcase
  end

  // physical memory
  always_ff @(posedge clk) begin
    if (phys_we) begin
      phys_mem[phys_wa] <= phys_wd;
    end
    if (phys_re) begin
      phys_rdata_r <= phys_mem[phys_ra];
    end
  end

  // swap memory
  always_ff @(posedge clk) begin
    if (swap_we) begin
      swap_mem[swap_wa] <= swap_wd;
    end
    if (swap_re) begin
      swap_rdata_r <= swap_mem[swap_ra];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        req_op_r <= in_operation;
        req_va_r <= in_virtual_address;
        req_wd_r <= in_write_data;
      end
      OP_WALK_CHK: begin
        if (w != '0) begin
          cur_r <= w_frame;
        end
      end
      OP_WALK_INIT: cur_r <= '0;
      OP_SCAN_INIT: begin
        frm_r[0] <= '0;
        idx_r[0] <= '0;
        emp_r[0] <= 1'b1;
        pg_r[0]  <= '0;
        top_r    <= '0;
      end
      OP_SCAN_CHK: begin
        if (w != '0) begin
          emp_r[dep_r] <= 1'b0;
          if (w_ok) begin
            if (w_frame > top_r) begin
              top_r <= w_frame;
            end
            if (leaf_child) begin
              if (!has_v_r || pg_dist > v_dist_r) begin
                v_dist_r   <= pg_dist;
                v_frame_r  <= w_frame;
                v_page_r   <= child_page;
                v_parent_r <= f_d;
                v_slot_r   <= i_d;
              end
            end else begin
              frm_r[dep_up]   <= w_frame;
              idx_r[dep_up]   <= '0;
              emp_r[dep_up]   <= 1'b1;
              pg_r[dep_up]    <= child_page;
              par_r[dep_up]   <= f_d;
              pslot_r[dep_up] <= i_d;
            end
          end
        end
      end
      OP_SCAN_NEXT: begin
        if (i_d != OFFSET_BITS'(PG_WORDS - 1)) begin
          idx_r[dep_r] <= i_d + OFFSET_BITS'(1);
        end else if (emp_r[dep_r] && dep_r != '0 && f_d != cur_r && !has_e_r) begin
          e_frame_r  <= f_d;
          e_parent_r <= par_r[dep_r];
          e_slot_r   <= pslot_r[dep_r];
        end
      end
      OP_PICK: begin
        if (has_e_r) begin
          nf_r <= e_frame_r;
        end else if (top_r != FRAME_BITS'(FRAME_COUNT - 1)) begin
          nf_r <= top_r + FRAME_BITS'(1);
        end else if (has_v_r) begin
          nf_r <= v_frame_r;
        end else begin
          nf_r <= '0;
        end
      end
      OP_LINK: cur_r <= nf_r;
      OP_RESULT: begin
        res_status_r <= va_bad;
        res_data_r   <= (va_bad || req_op_r) ? '0 : 32'($signed(phys_rdata_r));
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r   <= '0;
      fresh_r <= 1'b0;
      cnt_r   <= '0;
      clr_r   <= '0;
      dep_r   <= '0;
      has_e_r <= 1'b0;
      has_v_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_CLEAR: clr_r <= clr_r + SWAP_AW'(1);
        OP_WALK_INIT: begin
          lvl_r   <= '0;
          fresh_r <= 1'b0;
        end
        OP_WALK_CHK: begin
          if (w != '0 && !walk_last) begin
            lvl_r <= lvl_r + DEPTH_BITS'(1);
          end
        end
        OP_SCAN_INIT: begin
          dep_r   <= '0;
          has_e_r <= 1'b0;
          has_v_r <= 1'b0;
        end
        OP_SCAN_CHK: begin
          if (w != '0 && w_ok) begin
            if (leaf_child) begin
              has_v_r <= 1'b1;
            end else begin
              dep_r <= dep_up;
            end
          end
        end
        OP_SCAN_NEXT: begin
          if (i_d == OFFSET_BITS'(PG_WORDS - 1)) begin
            if (emp_r[dep_r] && dep_r != '0 && f_d != cur_r) begin
              has_e_r <= 1'b1;
            end
            if (dep_r != '0) begin
              dep_r <= dep_r - DEPTH_BITS'(1);
            end
          end
        end
        OP_EVICT, OP_FILL: begin
          cnt_r <= (cnt_r == CNT_BITS'(PG_WORDS)) ? '0 : cnt_r + CNT_BITS'(1);
        end
        OP_ZERO: begin
          cnt_r <= (cnt_r == CNT_BITS'(PG_WORDS - 1)) ? '0 : cnt_r + CNT_BITS'(1);
        end
        OP_LINK: begin
          fresh_r <= 1'b1;
          if (!walk_last) begin
            lvl_r <= lvl_r + DEPTH_BITS'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_status    = res_status_r;
  assign out_read_data = res_data_r;

endmodule

[sv/ptwa_ctrl.sv]
// ----------------------------------------------------------------------------
// ptwa_ctrl
// Controller: sequences the clearing pass, table walk, depth-first scan,
// frame allocation, page copies and the result handshake.
// ----------------------------------------------------------------------------
module ptwa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ptwa_pkg::dp_status_t status,
  output ptwa_pkg::dp_cmd_t    cmd
);
  import ptwa_pkg::*;

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_CHECK = 5'd2;
  localparam logic [4:0] S_WRD   = 5'd3;
  localparam logic [4:0] S_WCHK  = 5'd4;
  localparam logic [4:0] S_SINIT = 5'd5;
  localparam logic [4:0] S_SRD   = 5'd6;
  localparam logic [4:0] S_SCHK  = 5'd7;
  localparam logic [4:0] S_SNEXT = 5'd8;
  localparam logic [4:0] S_PICK  = 5'd9;
  localparam logic [4:0] S_EVICT = 5'd10;
  localparam logic [4:0] S_UNLV  = 5'd11;
  localparam logic [4:0] S_ZERO  = 5'd12;
  localparam logic [4:0] S_LINK  = 5'd13;
  localparam logic [4:0] S_FILL  = 5'd14;
  localparam logic [4:0] S_ACC   = 5'd15;
  localparam logic [4:0] S_RES   = 5'd16;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       load_res;

  // next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_IDLE;
    in_ready  = 1'b0;
    load_res  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (status.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.va_bad) begin
          state_nxt = S_RES;
        end else begin
          cmd.op    = OP_WALK_INIT;
          state_nxt = S_WRD;
        end
      end
      S_WRD: begin
        cmd.op    = OP_WALK_RD;
        state_nxt = S_WCHK;
      end
      S_WCHK: begin
        cmd.op = OP_WALK_CHK;
        if (status.walk_zero) begin
          state_nxt = S_SINIT;
        end else if (status.walk_last) begin
          state_nxt = status.fresh ? S_FILL : S_ACC;
        end else begin
          state_nxt = S_WRD;
        end
      end
      S_SINIT: begin
        cmd.op    = OP_SCAN_INIT;
        state_nxt = S_SRD;
      end
      S_SRD: begin
        cmd.op    = OP_SCAN_RD;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        cmd.op    = OP_SCAN_CHK;
        state_nxt = status.scan_push ? S_SRD : S_SNEXT;
      end
      S_SNEXT: begin
        cmd.op = OP_SCAN_NEXT;
        if (status.scan_done) begin
          state_nxt = S_PICK;
        end else if (status.scan_more) begin
          state_nxt = S_SRD;
        end
      end
      S_PICK: begin
        cmd.op = OP_PICK;
        if (status.need_evict) begin
          state_nxt = S_EVICT;
        end else begin
          state_nxt = status.walk_last ? S_LINK : S_ZERO;
        end
      end
      S_EVICT: begin
        cmd.op = OP_EVICT;
        if (status.copy_done) begin
          state_nxt = S_UNLV;
        end
      end
      S_UNLV: begin
        cmd.op    = OP_UNLINK;
        state_nxt = status.walk_last ? S_LINK : S_ZERO;
      end
      S_ZERO: begin
        cmd.op = OP_ZERO;
        if (status.zero_done) begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        cmd.op    = OP_LINK;
        state_nxt = status.walk_last ? S_FILL : S_WRD;
      end
      S_FILL: begin
        cmd.op = OP_FILL;
        if (status.copy_done) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.op    = OP_ACCESS;
        state_nxt = S_RES;
      end
      S_RES: begin
        if (!out_valid_r || out_ready) begin
          cmd.op    = OP_RESULT;
          load_res  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // output valid
  always_comb begin
    if (load_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[sv/page_table_walk_allocator.sv]
// ----------------------------------------------------------------------------
// page_table_walk_allocator
// Word read and write through a three-level page table held in an internal
// physical memory, with frame allocation, eviction to swap and restore.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel carries one request (operation, virtual address, write data);
//   out_* channel returns status and read data, one result per request.
//   Both channels use valid/ready; a request is taken only in the idle state.
// Sequence:
//   a request whose walk hits all levels is accepted and checked, reads one
//   table word per level, then does the access and returns the result. Each
//   missing level adds a depth-first scan of the table words in use, then a
//   page eviction to swap when no frame is free, and the zeroing of a new
//   table or, at the last level, the restore of the data page from swap.
// Reset:
//   a clearing pass zeroes the swap store and frame 0, with in_ready low
//   throughout.
// Stall:
//   the result waits in an output register; a new request may be taken while
//   it waits, and its result is held back until the pending one is taken.
// ----------------------------------------------------------------------------
module page_table_walk_allocator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [31:0]        in_virtual_address,
  input  logic signed [31:0] in_write_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_status,
  output logic signed [31:0] out_read_data
);
  import ptwa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  ptwa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // memories and walk datapath
  ptwa_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_operation       (in_operation),
    .in_virtual_address (in_virtual_address),
    .in_write_data      (in_write_data),
    .cmd                (cmd),
    .status             (status),
    .out_status         (out_status),
    .out_read_data      (out_read_data)
  );

endmodule
